// ===== hdl/sbtc_pkg.sv =====
`default_nettype none

package sbtc_pkg;

	// Field widths of the item and result transactions
	localparam int BIT_W   = 6;
	localparam int COUNT_W = 51;

	// Configuration register file
	localparam int MASK_W  = 16;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [MASK_W-1:0] MASK_RESET = 16'h0775;

	// Register index, taken from the word address bit of paddr
	localparam logic REG_ALLOWED_MASK = 1'b0;

	// Counts saturate here
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

endpackage

`default_nettype wire

// ===== hdl/sbtc_ifs.sv =====
`default_nettype none

// Item channel: start bit and round count
interface sbtc_req_if;
	import sbtc_pkg::*;

	logic               valid;
	logic               ready;
	logic [BIT_W-1:0]   start_bit;
	logic [BIT_W-1:0]   round_count;

	modport source (output valid, start_bit, round_count, input ready);
	modport sink   (input valid, start_bit, round_count, output ready);
endinterface

// Result channel: one count per end bit
interface sbtc_rsp_if;
	import sbtc_pkg::*;

	logic               valid;
	logic               ready;
	logic [BIT_W-1:0]   end_bit;
	logic [COUNT_W-1:0] trail_count;
	logic               last_result;

	modport source (output valid, end_bit, trail_count, last_result, input ready);
	modport sink   (input valid, end_bit, trail_count, last_result, output ready);
endinterface

`default_nettype wire

// ===== hdl/single_bit_trail_counter.sv =====
`default_nettype none

// Channel     Dir   Handshake      Payload
// trail_req   in    valid/ready    start_bit[5:0], round_count[5:0]
// trail_rsp   out   valid/ready    end_bit[5:0], trail_count[50:0], last_result
// apb         in    psel/penable   allowed_output_mask at paddr 0
//
// One item runs an init pass over the G = STATE_BITS/4 groups, then R rounds with R the
// clamped round count, then one result per state bit.
// In a round the saturating adder pair forms one destination count per cycle from one
// row read of the current count banks.
// arst_n clears the sequencer, pipeline valids and output valid, and loads MASK_RESET into the mask register.
// trail_req.ready is high only while idle; a stalled result holds the sequencer.

module single_bit_trail_counter #(
	parameter int STATE_BITS = 64,
	parameter int MAX_ROUNDS = 32
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            psel,
	input  wire                            penable,
	input  wire                            pwrite,
	input  wire [sbtc_pkg::PADDR_W-1:0]    paddr,
	input  wire [sbtc_pkg::PDATA_W-1:0]    pwdata,
	output logic [sbtc_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready,
	sbtc_req_if.sink                       trail_req,
	sbtc_rsp_if.source                     trail_rsp
);
	import sbtc_pkg::*;

	localparam int GROUPS    = STATE_BITS / 4;
	localparam int USED_BITS = GROUPS * 4;
	localparam int AW        = $clog2(GROUPS);
	localparam int DW        = AW + 2;
	localparam int EW        = $clog2(STATE_BITS);
	localparam int SUM_W     = COUNT_W + 2;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_INIT     = 3'd1;
	localparam logic [2:0] ST_ROUND    = 3'd2;
	localparam logic [2:0] ST_DRAIN    = 3'd3;
	localparam logic [2:0] ST_OUT_RD   = 3'd4;
	localparam logic [2:0] ST_OUT_LD   = 3'd5;
	localparam logic [2:0] ST_OUT_WAIT = 3'd6;

	logic [2:0]          state_q;
	logic [MASK_W-1:0]   mask_q;
	logic [BIT_W-1:0]    start_q;
	logic [BIT_W-1:0]    rounds_q;
	logic [AW-1:0]       g_q;
	logic [1:0]          t_q;
	logic [EW-1:0]       e_q;
	logic                cur_q;

	logic                v_s1, v_s2;
	logic [AW-1:0]       g_s1, g_s2;
	logic [1:0]          t_s1, t_s2;
	logic [COUNT_W:0]    p0_s2, p1_s2;

	logic                out_valid_q;
	logic [BIT_W-1:0]    end_q;
	logic [COUNT_W-1:0]  count_q;
	logic                last_q;

	logic                in_acc, out_acc, cfg_wr;
	logic [BIT_W-1:0]    rounds_in;
	logic [AW-1:0]       rd_addr;
	logic [COUNT_W-1:0]  rd_bank [2][4];
	logic [COUNT_W-1:0]  rd_cur  [4];
	logic [COUNT_W-1:0]  masked  [4];
	logic [SUM_W-1:0]    total;
	logic [COUNT_W-1:0]  sat_sum;
	logic [DW-1:0]       dst;
	logic                bank_we    [2][4];
	logic [AW-1:0]       bank_waddr [2][4];
	logic [COUNT_W-1:0]  bank_wdata [2][4];

	assign in_acc  = trail_req.valid && trail_req.ready;
	assign out_acc = trail_rsp.valid && trail_rsp.ready;
	assign cfg_wr  = psel && penable && pwrite && pready;

	// APB register file
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= MASK_RESET;
		end else if (cfg_wr && paddr[PADDR_W-1] == REG_ALLOWED_MASK) begin
			mask_q <= pwdata[MASK_W-1:0];
		end
	end

	always_comb begin
		unique case (paddr[PADDR_W-1])
			REG_ALLOWED_MASK: prdata = PDATA_W'(mask_q);
			default:          prdata = '0;
		endcase
	end

	// Clamp the round count
	assign rounds_in = (trail_req.round_count > BIT_W'(MAX_ROUNDS)) ?
		BIT_W'(MAX_ROUNDS) : trail_req.round_count;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			start_q     <= '0;
			rounds_q    <= '0;
			g_q         <= '0;
			t_q         <= '0;
			e_q         <= '0;
			cur_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						start_q  <= trail_req.start_bit;
						rounds_q <= rounds_in;
						g_q      <= '0;
						cur_q    <= 1'b0;
						state_q  <= ST_INIT;
					end
				end
				ST_INIT: begin
					if (g_q == AW'(GROUPS - 1)) begin
						g_q <= '0;
						t_q <= '0;
						e_q <= '0;
						state_q <= (rounds_q == '0) ? ST_OUT_RD : ST_ROUND;
					end else begin
						g_q <= g_q + 1'b1;
					end
				end
				ST_ROUND: begin
					t_q <= t_q + 1'b1;
					if (t_q == 2'd3) begin
						if (g_q == AW'(GROUPS - 1)) begin
							g_q     <= '0;
							state_q <= ST_DRAIN;
						end else begin
							g_q <= g_q + 1'b1;
						end
					end
				end
				ST_DRAIN: begin
					// last write has landed once both stages are empty
					if (!v_s1 && !v_s2) begin
						cur_q    <= ~cur_q;
						rounds_q <= rounds_q - 1'b1;
						e_q      <= '0;
						state_q  <= (rounds_q == BIT_W'(1)) ? ST_OUT_RD : ST_ROUND;
					end
				end
				ST_OUT_RD: begin
					state_q <= ST_OUT_LD;
				end
				ST_OUT_LD: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_OUT_WAIT;
				end
				ST_OUT_WAIT: begin
					if (out_acc) begin
						out_valid_q <= 1'b0;
						if (last_q) begin
							state_q <= ST_IDLE;
						end else begin
							e_q     <= e_q + 1'b1;
							state_q <= ST_OUT_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT_LD) begin
			end_q   <= BIT_W'(e_q);
			count_q <= (int'(e_q) < USED_BITS) ? rd_cur[e_q[1:0]] : '0;
			last_q  <= (int'(e_q) == STATE_BITS - 1);
		end
	end

	assign trail_req.ready       = (state_q == ST_IDLE);
	assign trail_rsp.valid       = out_valid_q;
	assign trail_rsp.end_bit     = end_q;
	assign trail_rsp.trail_count = count_q;
	assign trail_rsp.last_result = last_q;

	// Row address for both copies
	assign rd_addr = (state_q == ST_ROUND) ? g_q : AW'(e_q >> 2);

	// Count banks: two copies (current / next), four lanes of GROUPS rows each
	for (genvar c = 0; c < 2; c++) begin : g_copy
		for (genvar r = 0; r < 4; r++) begin : g_lane
			logic [COUNT_W-1:0] bank_q [GROUPS];
			logic [COUNT_W-1:0] rd_q;

			always_ff @(posedge clk) begin
				if (bank_we[c][r]) begin
					bank_q[bank_waddr[c][r]] <= bank_wdata[c][r];
				end
				rd_q <= bank_q[rd_addr];
			end

			assign rd_bank[c][r] = rd_q;
		end
	end

	// Lane data of the current copy, masked for output bit t_s1
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			rd_cur[r] = cur_q ? rd_bank[1][r] : rd_bank[0][r];
			masked[r] = mask_q[{2'(r), t_s1}] ? rd_cur[r] : '0;
		end
	end

	// Adder stage 1: pair sums; stage 2: total, saturate, write back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_ROUND);
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		g_s1  <= g_q;
		t_s1  <= t_q;
		g_s2  <= g_s1;
		t_s2  <= t_s1;
		p0_s2 <= {1'b0, masked[0]} + {1'b0, masked[1]};
		p1_s2 <= {1'b0, masked[2]} + {1'b0, masked[3]};
	end

	assign total   = {1'b0, p0_s2} + {1'b0, p1_s2};
	assign sat_sum = (total > SUM_W'(COUNT_MAX)) ? COUNT_MAX : total[COUNT_W-1:0];
	assign dst     = DW'(t_s2) * DW'(GROUPS) + DW'(g_s2);

	// Write ports: init clears the current copy and seeds a one at start_bit, a round fills the next copy
	always_comb begin
		for (int c = 0; c < 2; c++) begin
			for (int r = 0; r < 4; r++) begin
				if (state_q == ST_INIT && cur_q == 1'(c)) begin
					bank_we[c][r]    = 1'b1;
					bank_waddr[c][r] = g_q;
					bank_wdata[c][r] = (start_q == BIT_W'({g_q, 2'(r)})) ?
						COUNT_W'(1) : '0;
				end else begin
					bank_we[c][r]    = v_s2 && cur_q != 1'(c) && dst[1:0] == 2'(r);
					bank_waddr[c][r] = dst[DW-1:2];
					bank_wdata[c][r] = sat_sum;
				end
			end
		end
	end

	// Checks
	a_wb_in_round: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (state_q == ST_ROUND || state_q == ST_DRAIN))
		else $error("count write-back outside a round");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_INIT && !out_valid_q))
		else $error("accepted transaction did not start a run");

	a_last_is_top: assert property (@(posedge clk) disable iff (!arst_n)
		(trail_rsp.valid && trail_rsp.last_result) |->
		trail_rsp.end_bit == BIT_W'(STATE_BITS - 1))
		else $error("final result not on the top end bit");

	a_rounds_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rounds_q <= BIT_W'(MAX_ROUNDS))
		else $error("round counter above the clamp");

endmodule

`default_nettype wire
